FILE: hw/rtl/r2fft_pkg.sv
// Shared types and constants for the radix-2 frame FFT.
// No dependencies.
`default_nettype none
package r2fft_pkg;
    localparam int SMP_W = 16;
    localparam int TW_W  = 17;
    localparam int BIN_W = 6;

    // round(sin(2*pi*t/64) * 32768), t = 0..16
    function automatic logic signed [TW_W-1:0] qsine(input logic [4:0] t);
        logic signed [TW_W-1:0] v;
        unique case (t)
            5'd0:  v = 17'sd0;
            5'd1:  v = 17'sd3212;
            5'd2:  v = 17'sd6393;
            5'd3:  v = 17'sd9512;
            5'd4:  v = 17'sd12540;
            5'd5:  v = 17'sd15447;
            5'd6:  v = 17'sd18205;
            5'd7:  v = 17'sd20788;
            5'd8:  v = 17'sd23170;
            5'd9:  v = 17'sd25330;
            5'd10: v = 17'sd27246;
            5'd11: v = 17'sd28899;
            5'd12: v = 17'sd30274;
            5'd13: v = 17'sd31357;
            5'd14: v = 17'sd32138;
            5'd15: v = 17'sd32610;
            default: v = 17'sd32768;
        endcase
        return v;
    endfunction

    // sin(2*pi*t/64), t taken mod 64
    function automatic logic signed [TW_W-1:0] sine64(input logic [5:0] t);
        logic signed [TW_W-1:0] v;
        if (t <= 6'd16)      v = qsine(t[4:0]);
        else if (t <= 6'd32) v = qsine(5'(6'd32 - t));
        else if (t <= 6'd48) v = -qsine(5'(t - 6'd32));
        else                 v = -qsine(5'(7'd64 - {1'b0, t}));
        return v;
    endfunction

    // round half up with a shift of 16, saturate to 16 bits
    function automatic logic signed [SMP_W-1:0] round_half(input logic signed [33:0] v);
        logic signed [33:0] s;
        logic signed [17:0] r;
        s = v + 34'sd32768;
        r = s[33:16];
        if (r > 18'sd32767)       return 16'sh7fff;
        else if (r < -18'sd32768) return 16'sh8000;
        else                      return r[15:0];
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/r2fft_bfly.sv
// Butterfly datapath: registered products, then sum, difference and rounding.
// Uses r2fft_pkg.
`default_nettype none
module r2fft_bfly (
    input  wire logic                               i_clk,
    input  wire logic signed [r2fft_pkg::SMP_W-1:0] i_ar,
    input  wire logic signed [r2fft_pkg::SMP_W-1:0] i_ai,
    input  wire logic signed [r2fft_pkg::SMP_W-1:0] i_br,
    input  wire logic signed [r2fft_pkg::SMP_W-1:0] i_bi,
    input  wire logic signed [r2fft_pkg::TW_W-1:0]  i_c,
    input  wire logic signed [r2fft_pkg::TW_W-1:0]  i_s,
    output logic signed [r2fft_pkg::SMP_W-1:0]      o_ar,
    output logic signed [r2fft_pkg::SMP_W-1:0]      o_ai,
    output logic signed [r2fft_pkg::SMP_W-1:0]      o_br,
    output logic signed [r2fft_pkg::SMP_W-1:0]      o_bi
);
    import r2fft_pkg::*;
    logic signed [32:0] r_cbr, r_sbi, r_cbi, r_sbr;
    logic signed [SMP_W-1:0] r_ar, r_ai;
    logic signed [33:0] tr, ti, ar, ai;

    always_ff @(posedge i_clk) begin
        r_cbr <= i_c * i_br;
        r_sbi <= i_s * i_bi;
        r_cbi <= i_c * i_bi;
        r_sbr <= i_s * i_br;
        r_ar  <= i_ar;
        r_ai  <= i_ai;
    end

    always_comb begin
        tr = 34'(r_cbr) + 34'(r_sbi);
        ti = 34'(r_cbi) - 34'(r_sbr);
        ar = 34'(r_ar) <<< 15;
        ai = 34'(r_ai) <<< 15;
        o_ar = round_half(ar + tr);
        o_ai = round_half(ai + ti);
        o_br = round_half(ar - tr);
        o_bi = round_half(ai - ti);
    end
endmodule
`default_nettype wire

FILE: hw/rtl/radix2_fft_frame.sv
// Radix-2 DIT FFT over a frame of POINTS real samples, output scaled by 1/POINTS.
// Uses r2fft_pkg and r2fft_bfly.
// Samples are taken one per cycle and written at bit-reversed addresses of a
// complex sample memory. After the last sample of a frame the block runs
// LOG2_POINTS passes of POINTS/2 butterflies; each butterfly steps through read a,
// latch a, read b, product, write b and write a on the one sample memory. Bins
// leave in order, one per cycle while i_ready is high, through an output register;
// no sample is accepted until the last bin of a frame is taken.
`default_nettype none
module radix2_fft_frame #(
    parameter int POINTS      = 64,
    parameter int LOG2_POINTS = 6
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic signed [r2fft_pkg::SMP_W-1:0] i_sample,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [r2fft_pkg::BIN_W-1:0]             o_bin_index,
    output logic signed [r2fft_pkg::SMP_W-1:0]      o_bin_real,
    output logic signed [r2fft_pkg::SMP_W-1:0]      o_bin_imag,
    output logic                                    o_last_bin
);
    import r2fft_pkg::*;
    localparam int AW = LOG2_POINTS;
    localparam int SW = (LOG2_POINTS > 1) ? $clog2(LOG2_POINTS) : 1;

    typedef enum logic [2:0] {S_FILL, S_RD, S_MUL, S_WR, S_OUT_RD, S_OUT} t_state;

    logic [2*SMP_W-1:0] mem [POINTS];
    t_state r_state;
    logic [AW-1:0] r_cnt;          // sample count, butterfly index, or bin
    logic [SW-1:0] r_stage;
    logic [AW-1:0] r_a, r_b;
    logic signed [SMP_W-1:0] r_xr, r_xi;
    logic signed [TW_W-1:0] r_c, r_s;
    logic [2*SMP_W-1:0] r_rd;
    logic r_first;
    logic signed [SMP_W-1:0] w_ar, w_ai, w_br, w_bi;

    // butterfly addressing
    logic [AW-1:0] half, m, a_idx, b_idx, hi;
    logic [5:0] tw;
    logic [AW-1:0] rev;
    always_comb begin
        half = AW'(1) << r_stage;
        m = r_cnt & (half - AW'(1));
        hi = (r_cnt >> r_stage) << (r_stage + 1);
        a_idx = hi | m;
        b_idx = a_idx | half;
        tw = 6'(({{(6 - AW + 1){1'b0}}, m[AW-2:0]}) << (5 - r_stage));
        for (int k = 0; k < AW; k++) rev[k] = r_cnt[AW-1-k];
    end

    r2fft_bfly u_bfly (
        .i_clk(i_clk), .i_ar(r_xr), .i_ai(r_xi),
        .i_br(r_rd[2*SMP_W-1:SMP_W]), .i_bi(r_rd[SMP_W-1:0]),
        .i_c(r_c), .i_s(r_s),
        .o_ar(w_ar), .o_ai(w_ai), .o_br(w_br), .o_bi(w_bi)
    );

    // memory: one write and one registered read per cycle
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [2*SMP_W-1:0] mem_wd;
    always_comb begin
        mem_we = 1'b0;
        mem_wa = rev;
        mem_wd = {i_sample, {SMP_W{1'b0}}};
        mem_ra = r_cnt;
        unique case (r_state)
            S_FILL: mem_we = i_valid;
            S_RD:   mem_ra = r_first ? a_idx : b_idx;
            S_MUL:  mem_ra = r_b;
            S_WR: begin
                mem_we = 1'b1;
                mem_wa = r_first ? r_b : r_a;
                mem_wd = r_first ? {w_br, w_bi} : {w_ar, w_ai};
                mem_ra = r_b;
            end
            S_OUT:  mem_ra = (!o_valid || i_ready) ? r_cnt + AW'(1) : r_cnt;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd <= mem[mem_ra];
    end

    assign o_ready = (r_state == S_FILL);

    // sequencing: S_RD issues a read (a first, then b); S_MUL latches a; S_WR writes b, then a
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_cnt   <= '0;
            r_stage <= '0;
            r_first <= 1'b1;
            o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_FILL: if (i_valid) begin
                    r_cnt <= r_cnt + AW'(1);
                    if (r_cnt == AW'(POINTS - 1)) begin
                        r_state <= S_RD;
                        r_stage <= '0;
                        r_first <= 1'b1;
                    end
                end
                S_RD: begin
                    r_a <= a_idx;
                    r_b <= b_idx;
                    r_c <= sine64(6'(tw + 6'd16));
                    r_s <= sine64(tw);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_first) begin
                        r_xr <= r_rd[2*SMP_W-1:SMP_W];
                        r_xi <= r_rd[SMP_W-1:0];
                        r_first <= 1'b0;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_WR;
                        r_first <= 1'b1;
                    end
                end
                S_WR: begin
                    if (r_first) begin
                        r_first <= 1'b0;
                    end else begin
                        r_first <= 1'b1;
                        if (r_cnt == AW'(POINTS / 2 - 1)) begin
                            r_cnt <= '0;
                            if (r_stage == SW'(LOG2_POINTS - 1)) begin
                                r_state <= S_OUT_RD;
                            end else begin
                                r_stage <= r_stage + SW'(1);
                                r_state <= S_RD;
                            end
                        end else begin
                            r_cnt <= r_cnt + AW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_OUT_RD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid || i_ready) begin
                        if (o_valid && o_last_bin) begin
                            o_valid <= 1'b0;
                            r_cnt <= '0;
                            r_state <= S_FILL;
                        end else begin
                            o_valid <= 1'b1;
                            o_bin_index <= BIN_W'(r_cnt);
                            o_bin_real <= r_rd[2*SMP_W-1:SMP_W];
                            o_bin_imag <= r_rd[SMP_W-1:0];
                            o_last_bin <= (r_cnt == AW'(POINTS - 1));
                            r_cnt <= r_cnt + AW'(1);
                        end
                    end
                end
                default: r_state <= S_FILL;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/r2fft_checker.sv
// Port-level checks for radix2_fft_frame, bound to the top level.
// Depends on radix2_fft_frame ports only.
`default_nettype none
module r2fft_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [5:0] o_bin_index,
    input wire logic       o_last_bin
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_bin_index)) else $error("output dropped");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("input open during drain");
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> o_bin_index == 6'd0) else $error("drain not at bin zero");
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_bin |=> o_valid && o_bin_index == $past(o_bin_index) + 6'd1)
        else $error("bin order");
endmodule

bind radix2_fft_frame r2fft_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_bin_index(o_bin_index),
    .o_last_bin(o_last_bin)
);
`default_nettype wire

FILE: verif/tb_radix2_fft_frame.sv
// Testbench for radix2_fft_frame: 64-point frames go in with random gaps, bins come out
// under random back-pressure and are checked against a behavioral fixed-point FFT or,
// for the constant frames, a known DC result. Depends on r2fft_pkg and the radix2_fft_frame RTL.
`default_nettype none
module tb_radix2_fft_frame;
    timeunit 1ns;
    timeprecision 1ps;
    import r2fft_pkg::*;

    localparam int NPTS       = 64;
    localparam int NLOG       = 6;
    localparam int RAND_FRAMES = 2;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {FR_CONST, FR_ALT, FR_IMPULSE} t_frame_kind;

    typedef struct {
        t_frame_kind kind;
        int          amp;
        bit          known;
    } t_frame_row;

    typedef struct {
        logic [BIN_W-1:0]        idx;
        logic signed [SMP_W-1:0] re;
        logic signed [SMP_W-1:0] im;
        logic                    last;
    } t_bin;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    i_ready = 1'b0;
    logic signed [SMP_W-1:0] i_sample = '0;
    logic                    o_ready, o_valid, o_last_bin;
    logic [BIN_W-1:0]        o_bin_index;
    logic signed [SMP_W-1:0] o_bin_real, o_bin_imag;

    radix2_fft_frame #(.POINTS(NPTS), .LOG2_POINTS(NLOG)) dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // frame model
    int                      quarter_tab [17] = '{0, 3212, 6393, 9512, 12540, 15447, 18205,
        20788, 23170, 25330, 27246, 28899, 30274, 31357, 32138, 32610, 32768};
    logic signed [SMP_W-1:0] re_mem [NPTS];
    logic signed [SMP_W-1:0] im_mem [NPTS];
    int                      fill_cnt = 0;
    t_bin                    pending_bins [$];

    int  err_cnt = 0;
    int  bins_seen = 0;
    int  frames_done = 0;
    int  cycles = 0;
    bit  burst_tx = 0, burst_rx = 0;

    function automatic int twiddle_sin(int t);
        t = t & 63;
        if (t <= 16) return quarter_tab[t];
        if (t <= 32) return quarter_tab[32 - t];
        if (t <= 48) return -quarter_tab[t - 32];
        return -quarter_tab[64 - t];
    endfunction

    function automatic int rev_addr(int m);
        int r;
        r = 0;
        for (int b = 0; b < NLOG; b++) r = (r << 1) | ((m >> b) & 1);
        return r;
    endfunction

    function automatic logic signed [SMP_W-1:0] halve_round(longint v);
        longint r;
        r = (v + 32768) >>> 16;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic void transform_frame();
        int     half, tw, a, b;
        longint c, sn, br, bi, tr, ti, ar, ai;
        for (int s = 0; s < NLOG; s++) begin
            half = 1 << s;
            for (int m = 0; m < half; m++) begin
                tw = (m << (5 - s)) & 63;
                c  = twiddle_sin(tw + 16);
                sn = twiddle_sin(tw);
                for (int i = m; i < NPTS; i += 2 * half) begin
                    a  = i;
                    b  = i + half;
                    br = re_mem[b];
                    bi = im_mem[b];
                    tr = c * br + sn * bi;
                    ti = c * bi - sn * br;
                    ar = longint'(re_mem[a]) * 32768;
                    ai = longint'(im_mem[a]) * 32768;
                    re_mem[b] = halve_round(ar - tr);
                    im_mem[b] = halve_round(ai - ti);
                    re_mem[a] = halve_round(ar + tr);
                    im_mem[a] = halve_round(ai + ti);
                end
            end
        end
    endfunction

    // returns 1 when the sample completes a frame
    function automatic bit absorb_sample(logic signed [SMP_W-1:0] smp);
        int addr;
        addr = rev_addr(fill_cnt);
        re_mem[addr] = smp;
        im_mem[addr] = '0;
        fill_cnt++;
        if (fill_cnt < NPTS) return 0;
        fill_cnt = 0;
        transform_frame();
        return 1;
    endfunction

    task automatic send_sample(logic signed [SMP_W-1:0] smp, bit typed, int dc);
        int   gap;
        bit   acc;
        t_bin e;
        gap = burst_tx ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= smp;
        do begin
            @(negedge i_clk);
            acc = o_ready;
            @(posedge i_clk);
        end while (!acc);
        if (absorb_sample(smp)) begin
            for (int k = 0; k < NPTS; k++) begin
                e.idx  = k[BIN_W-1:0];
                e.re   = typed ? ((k == 0) ? dc[15:0] : 16'sd0) : re_mem[k];
                e.im   = typed ? 16'sd0 : im_mem[k];
                e.last = (k == NPTS - 1);
                pending_bins.push_back(e);
            end
        end
    endtask

    // bin collector with random back-pressure
    initial begin
        int   stall;
        bit   acc;
        t_bin got, want;
        @(posedge i_rst_n);
        forever begin
            stall = burst_rx ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do begin
                @(negedge i_clk);
                acc = o_valid;
                got = '{o_bin_index, o_bin_real, o_bin_imag, o_last_bin};
                @(posedge i_clk);
            end while (!acc);
            bins_seen++;
            if (pending_bins.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) $display("unexpected bin %0d re %0d im %0d",
                                            got.idx, got.re, got.im);
            end else begin
                want = pending_bins.pop_front();
                if (got.last) frames_done++;
                if (got.idx !== want.idx || got.re !== want.re ||
                    got.im !== want.im || got.last !== want.last) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display({"bin mismatch: exp idx %0d re %0d im %0d last %0b,",
                                  " got idx %0d re %0d im %0d last %0b"},
                                 want.idx, want.re, want.im, want.last,
                                 got.idx, got.re, got.im, got.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d bins pending", pending_bins.size());
            $display("radix2_fft_frame regression: fail");
            $finish;
        end
    end

    t_frame_row frame_tab [] = '{
        '{FR_CONST,   0,      1},
        '{FR_CONST,   32767,  1},
        '{FR_CONST,   -32768, 1},
        '{FR_ALT,     32767,  0},
        '{FR_IMPULSE, -32768, 0}
    };

    initial begin
        logic signed [SMP_W-1:0] smp;
        int                      pick;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (frame_tab[r]) begin
            burst_tx = (r == 1);
            burst_rx = (r == 2);
            for (int n = 0; n < NPTS; n++) begin
                case (frame_tab[r].kind)
                    FR_CONST:   smp = frame_tab[r].amp[15:0];
                    FR_ALT:     smp = n[0] ? 16'sh8000 : 16'sh7fff;
                    default:    smp = (n == 1) ? frame_tab[r].amp[15:0] : 16'sd0;
                endcase
                send_sample(smp, frame_tab[r].known, frame_tab[r].amp);
            end
        end

        for (int f = 0; f < RAND_FRAMES; f++) begin
            burst_tx = ($urandom_range(0, 3) == 0);
            burst_rx = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < NPTS; n++) begin
                pick = $urandom_range(0, 7);
                if (pick == 0)      smp = 16'sh7fff;
                else if (pick == 1) smp = 16'sh8000;
                else                smp = SMP_W'($urandom);
                send_sample(smp, 0, 0);
            end
        end
        i_valid <= 1'b0;

        while (pending_bins.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("%0d frames (%0d directed, %0d random) and %0d bins checked, %0d errors",
                 frames_done, frame_tab.size(), RAND_FRAMES, bins_seen, err_cnt);
        if (err_cnt == 0 && pending_bins.size() == 0) begin
            $display("radix2_fft_frame regression: pass");
        end else begin
            $display("radix2_fft_frame regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: radix2_fft_frame.f
hw/rtl/r2fft_pkg.sv
hw/rtl/r2fft_bfly.sv
hw/rtl/radix2_fft_frame.sv
hw/rtl/r2fft_checker.sv
verif/tb_radix2_fft_frame.sv
